@@ sv/sst_pkg.sv @@
// ---------------------------------------------------------------------------
// sst_pkg
// Shared constants and types for the strongest signal table.
// ---------------------------------------------------------------------------
`default_nettype none
package sst_pkg;
    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int ADDR_W   = 48;
    localparam int TAG_W    = 32;
    localparam int SIG_W    = 8;
    localparam int ENTRY_W  = ADDR_W + TAG_W + SIG_W;
    localparam int MAX_OUT  = 16;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_REPORT  = 2'd1;
    localparam logic [1:0] OP_FINISH  = 2'd2;
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [TAG_W-1:0]  name_tag;
        logic [SIG_W-1:0]  strength;
    } entry_t;
endpackage
`default_nettype wire

@@ sv/strongest_signal_table.sv @@
// ---------------------------------------------------------------------------
// strongest_signal_table
// Bounded table of the strongest advertisers seen during one scan.
// ---------------------------------------------------------------------------
// Entries live in one RAM with a registered read. A report is accepted,
// then scans the held entries in turn (read, then compare), stopping at an
// address match, and ends with a write-back. A finish runs an in-place
// insertion sort over the RAM (quadratic in the entry count), then reads
// out one entry per result (read, wait, send), each result held while the
// sink stalls. A clear is done on acceptance. One item is processed at a
// time.
`default_nettype none
module strongest_signal_table
    import sst_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_tvalid,
    output logic         s_tready,
    // opcode[1:0], address[49:2], name_tag[81:50], signal_strength[89:82],
    // end_error[90], zero fill
    input  wire  [95:0]  s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // entry_valid[0], entry_address[48:1], entry_name_tag[80:49],
    // entry_strength[88:81], rank[92:89], total_seen[108:93],
    // shown_count[113:109], scan_failed_flag[114], zero fill
    output logic [119:0] m_tdata,
    output logic         m_tlast
);
    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_SCAN   = 4'd1;
    localparam logic [3:0] ST_SCANW  = 4'd2;
    localparam logic [3:0] ST_WRITE  = 4'd3;
    localparam logic [3:0] ST_SKEY   = 4'd4;
    localparam logic [3:0] ST_SKEYW  = 4'd5;
    localparam logic [3:0] ST_SCMP   = 4'd6;
    localparam logic [3:0] ST_SCMPW  = 4'd7;
    localparam logic [3:0] ST_SPUT   = 4'd8;
    localparam logic [3:0] ST_OREAD  = 4'd9;
    localparam logic [3:0] ST_OWAIT  = 4'd10;
    localparam logic [3:0] ST_OSEND  = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [15:0]         seen_reg, seen_next;
    logic                failed_reg, failed_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    entry_t              req_reg, req_next;
    logic [IW-1:0]       hit_reg, hit_next;
    logic                found_reg, found_next;
    logic [IW-1:0]       weak_reg, weak_next;
    logic [SIG_W-1:0]    weak_sig_reg, weak_sig_next;
    entry_t              out_reg, out_next;
    logic                ovalid_reg, ovalid_next;
    logic                olast_reg, olast_next;
    logic [3:0]          orank_reg, orank_next;
    logic [CW-1:0]       on_reg, on_next;

    logic                we;
    logic [IW-1:0]       waddr, raddr;
    entry_t              wdata, rdata;
    logic [ENTRY_W-1:0]  rdata_raw;
    logic                s_acc;

    sst_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );
    assign rdata = entry_t'(rdata_raw);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;

    // next-state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        seen_next     = seen_reg;
        failed_next   = failed_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        req_next      = req_reg;
        hit_next      = hit_reg;
        found_next    = found_reg;
        weak_next     = weak_reg;
        weak_sig_next = weak_sig_reg;
        out_next      = out_reg;
        ovalid_next   = ovalid_reg;
        olast_next    = olast_reg;
        orank_next    = orank_reg;
        on_next       = on_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = req_reg;
        raddr         = i_reg[IW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (s_acc)
                begin
                    req_next.address  = s_tdata[49:2];
                    req_next.name_tag = s_tdata[81:50];
                    req_next.strength = s_tdata[89:82];
                    i_next     = '0;
                    found_next = 1'b0;
                    weak_next  = '0;
                    case (s_tdata[1:0])
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            seen_next   = '0;
                            failed_next = 1'b0;
                        end
                        OP_REPORT:
                        begin
                            seen_next  = seen_reg + 16'd1;
                            state_next = (count_reg == '0) ? ST_WRITE : ST_SCAN;
                        end
                        OP_FINISH:
                        begin
                            failed_next = s_tdata[90] && (seen_reg == 16'd0);
                            i_next      = CW'(1);
                            state_next  = ST_SKEY;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            // issue read of entry i
            ST_SCAN:
            begin
                state_next = ST_SCANW;
            end
            // compare entry i against the request
            ST_SCANW:
            begin
                if (rdata.address == req_reg.address)
                begin
                    found_next = 1'b1;
                    hit_next   = i_reg[IW-1:0];
                    out_next   = rdata;
                    state_next = ST_WRITE;
                end
                else
                begin
                    if (i_reg == '0 ||
                        $signed(rdata.strength) < $signed(weak_sig_reg))
                    begin
                        weak_next     = i_reg[IW-1:0];
                        weak_sig_next = rdata.strength;
                    end
                    if (i_reg + CW'(1) == count_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            // write back the update, append or replacement
            ST_WRITE:
            begin
                state_next = ST_IDLE;
                if (found_reg)
                begin
                    if ($signed(req_reg.strength) > $signed(out_reg.strength))
                    begin
                        we    = 1'b1;
                        waddr = hit_reg;
                        wdata = out_reg;
                        wdata.strength = req_reg.strength;
                        if (req_reg.name_tag != '0)
                        begin
                            wdata.name_tag = req_reg.name_tag;
                        end
                    end
                end
                else if (count_reg < CW'(TABLE_DEPTH))
                begin
                    we         = 1'b1;
                    waddr      = count_reg[IW-1:0];
                    count_next = count_reg + CW'(1);
                end
                else if ($signed(req_reg.strength) > $signed(weak_sig_reg))
                begin
                    we    = 1'b1;
                    waddr = weak_reg;
                end
            end
            // sort: fetch key at i
            ST_SKEY:
            begin
                if (i_reg >= count_reg)
                begin
                    i_next     = '0;
                    orank_next = '0;
                    on_next    = (TABLE_DEPTH > MAX_OUT && count_reg > CW'(MAX_OUT)) ?
                                 CW'(MAX_OUT) : count_reg;
                    state_next = ST_OREAD;
                end
                else
                begin
                    state_next = ST_SKEYW;
                end
            end
            ST_SKEYW:
            begin
                req_next   = rdata;
                j_next     = i_reg;
                raddr      = IW'(i_reg - CW'(1));
                state_next = ST_SCMP;
            end
            // sort: read j-1 and shift it up while weaker than the key
            ST_SCMP:
            begin
                raddr      = IW'(j_reg - CW'(1));
                state_next = ST_SCMPW;
            end
            ST_SCMPW:
            begin
                if ($signed(rdata.strength) < $signed(req_reg.strength))
                begin
                    we     = 1'b1;
                    waddr  = j_reg[IW-1:0];
                    wdata  = rdata;
                    j_next = j_reg - CW'(1);
                    state_next = (j_reg == CW'(1)) ? ST_SPUT : ST_SCMP;
                end
                else
                begin
                    state_next = ST_SPUT;
                end
            end
            ST_SPUT:
            begin
                we         = 1'b1;
                waddr      = j_reg[IW-1:0];
                wdata      = req_reg;
                i_next     = i_reg + CW'(1);
                state_next = ST_SKEY;
            end
            // readout
            ST_OREAD:
            begin
                state_next = ST_OWAIT;
            end
            ST_OWAIT:
            begin
                if (on_reg == '0)
                begin
                    out_next    = '0;
                    ovalid_next = 1'b0;
                    olast_next  = 1'b1;
                end
                else
                begin
                    out_next    = rdata;
                    ovalid_next = 1'b1;
                    olast_next  = (i_reg + CW'(1) >= on_reg);
                end
                orank_next = 4'(i_reg);
                state_next = ST_OSEND;
            end
            ST_OSEND:
            begin
                if (m_tready)
                begin
                    if (olast_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next     = i_reg + CW'(1);
                        raddr      = IW'(i_reg + CW'(1));
                        state_next = ST_OWAIT;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            seen_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
            failed_reg <= failed_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        req_reg      <= req_next;
        hit_reg      <= hit_next;
        found_reg    <= found_next;
        weak_reg     <= weak_next;
        weak_sig_reg <= weak_sig_next;
        out_reg      <= out_next;
        ovalid_reg   <= ovalid_next;
        olast_reg    <= olast_next;
        orank_reg    <= orank_next;
        on_reg       <= on_next;
    end

    // output mapping
    assign m_tvalid = (state_reg == ST_OSEND);
    assign m_tlast  = olast_reg;
    assign m_tdata  = {5'd0, failed_reg, 5'(count_reg), seen_reg, orank_reg,
                       out_reg.strength, out_reg.name_tag, out_reg.address,
                       ovalid_reg};

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count overflow");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");
    a_seen_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> $stable(seen_reg))
        else $error("report count changed while busy");
`endif
endmodule
`default_nettype wire

@@ sv/sst_ram.sv @@
// ---------------------------------------------------------------------------
// sst_ram
// Generic single-port write, single-port read RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module sst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                         clk,
    input  wire                                         we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire  [WIDTH-1:0]                            wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Checks the strongest signal table against a behavioral table model: mixed
// clear, report and finish requests with random stalls on both stream sides.
// ---------------------------------------------------------------------------
module testbench
    import sst_pkg::*;
;
    localparam int DEPTH = 16;

    typedef struct packed {
        logic        entry_valid;
        logic [47:0] address;
        logic [31:0] name_tag;
        logic [7:0]  strength;
        logic [3:0]  rank;
        logic [15:0] total_seen;
        logic [4:0]  shown_count;
        logic        scan_failed;
        logic        last;
    } readout_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic         m_tlast;

    // pending requests and expected readout entries
    logic [95:0] request_queue[$];
    readout_t    readout_queue[$];
    int          mismatch_count = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          stim_done = 0;

    // model state
    logic [47:0] tbl_addr[DEPTH];
    logic [31:0] tbl_tag[DEPTH];
    logic [7:0]  tbl_sig[DEPTH];
    int          tbl_count = 0;
    logic [15:0] report_total = 0;
    logic        failed_flag = 0;

    strongest_signal_table i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // apply one request to the table model, queue the readout it causes
    task automatic model_request(input logic [95:0] d);
        logic [1:0]  op;
        logic [47:0] a;
        logic [31:0] t;
        logic [7:0]  s;
        logic [47:0] ka;
        logic [31:0] kt;
        logic [7:0]  ks;
        int          w;
        int          j;
        bit          hit;
        readout_t    r;
        op = d[1:0];
        a = d[49:2];
        t = d[81:50];
        s = d[89:82];
        hit = 0;
        if (op == OP_CLEAR) begin
            tbl_count = 0;
            report_total = 0;
            failed_flag = 0;
        end else if (op == OP_REPORT) begin
            report_total = report_total + 16'd1;
            for (int i = 0; i < tbl_count; i++) begin
                if (!hit && tbl_addr[i] == a) begin
                    hit = 1;
                    if ($signed(s) > $signed(tbl_sig[i])) begin
                        tbl_sig[i] = s;
                        if (t != 0) tbl_tag[i] = t;
                    end
                end
            end
            if (!hit) begin
                if (tbl_count >= DEPTH) begin
                    w = 0;
                    for (int i = 1; i < DEPTH; i++)
                        if ($signed(tbl_sig[i]) < $signed(tbl_sig[w])) w = i;
                    if ($signed(s) > $signed(tbl_sig[w])) begin
                        tbl_addr[w] = a;
                        tbl_tag[w] = t;
                        tbl_sig[w] = s;
                    end
                end else begin
                    tbl_addr[tbl_count] = a;
                    tbl_tag[tbl_count] = t;
                    tbl_sig[tbl_count] = s;
                    tbl_count++;
                end
            end
        end else if (op == OP_FINISH) begin
            failed_flag = d[90] && report_total == 0;
            // stable insertion sort, strongest first
            for (int i = 1; i < tbl_count; i++) begin
                ka = tbl_addr[i];
                kt = tbl_tag[i];
                ks = tbl_sig[i];
                j = i;
                while (j > 0 && $signed(tbl_sig[j-1]) < $signed(ks)) begin
                    tbl_addr[j] = tbl_addr[j-1];
                    tbl_tag[j] = tbl_tag[j-1];
                    tbl_sig[j] = tbl_sig[j-1];
                    j--;
                end
                tbl_addr[j] = ka;
                tbl_tag[j] = kt;
                tbl_sig[j] = ks;
            end
            r = '0;
            r.total_seen = report_total;
            r.shown_count = tbl_count[4:0];
            r.scan_failed = failed_flag;
            if (tbl_count == 0) begin
                r.last = 1;
                readout_queue.push_back(r);
            end
            for (int k = 0; k < tbl_count; k++) begin
                r.entry_valid = 1;
                r.address = tbl_addr[k];
                r.name_tag = tbl_tag[k];
                r.strength = tbl_sig[k];
                r.rank = k[3:0];
                r.last = (k == tbl_count - 1);
                readout_queue.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic logic [95:0] pack_req(logic [1:0] op, logic [47:0] a,
                                             logic [31:0] t, logic [7:0] s,
                                             logic e);
        return {5'd0, e, s, t, a, op};
    endfunction

    // driver: the model is updated when the request is accepted
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 0;
            s_tdata <= '0;
        end else begin
            if (s_tvalid && s_tready) model_request(s_tdata);
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 0;
                end else if (request_queue.size() > 0) begin
                    s_tdata <= request_queue.pop_front();
                    s_tvalid <= 1;
                    send_gap = pick_gap();
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // monitor and sink stalls
    always @(posedge clk or negedge rst_n) begin
        readout_t want;
        if (!rst_n) begin
            m_tready <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (readout_queue.size() == 0) begin
                    report_mismatch("unexpected readout", m_tdata[63:0], 0);
                end else begin
                    want = readout_queue.pop_front();
                    if (m_tdata[0] !== want.entry_valid)
                        report_mismatch("entry_valid", m_tdata[0], want.entry_valid);
                    if (m_tdata[48:1] !== want.address)
                        report_mismatch("entry_address", m_tdata[48:1], want.address);
                    if (m_tdata[80:49] !== want.name_tag)
                        report_mismatch("entry_name_tag", m_tdata[80:49], want.name_tag);
                    if (m_tdata[88:81] !== want.strength)
                        report_mismatch("entry_strength", m_tdata[88:81], want.strength);
                    if (m_tdata[92:89] !== want.rank)
                        report_mismatch("rank", m_tdata[92:89], want.rank);
                    if (m_tdata[108:93] !== want.total_seen)
                        report_mismatch("total_seen", m_tdata[108:93], want.total_seen);
                    if (m_tdata[113:109] !== want.shown_count)
                        report_mismatch("shown_count", m_tdata[113:109], want.shown_count);
                    if (m_tdata[114] !== want.scan_failed)
                        report_mismatch("scan_failed_flag", m_tdata[114], want.scan_failed);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                recv_gap = pick_gap();
            end
        end
    end

    // random address drawn from a small pool so repeats are common
    function automatic logic [47:0] pool_addr(int pool);
        logic [47:0] a;
        a = 48'({$urandom, $urandom});
        if ($urandom_range(0, 9) < 8)
            a = {a[47:8] & 40'h0, 8'(a[7:0] % pool)} ^ 48'hA5A5_0000_0000;
        if ($urandom_range(0, 19) == 0) a = ~a;
        return a;
    endfunction

    initial begin
        int n_scan;
        int pool;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;

        // directed: empty finishes, extremes, equal strengths, table overflow
        request_queue.push_back(pack_req(OP_FINISH, '0, '0, '0, 1'b1));
        request_queue.push_back(pack_req(OP_FINISH, '0, '0, '0, 1'b0));
        request_queue.push_back(pack_req(OP_IGNORED, '1, '1, '1, 1'b1));
        request_queue.push_back(pack_req(OP_REPORT, '1, '1, 8'h7f, 1'b1));
        request_queue.push_back(pack_req(OP_REPORT, '0, '0, 8'h80, 1'b0));
        request_queue.push_back(pack_req(OP_REPORT, 48'h1, 32'h5, 8'h80, 1'b0));
        request_queue.push_back(pack_req(OP_REPORT, 48'h1, 32'h6, 8'h80, 1'b0));
        request_queue.push_back(pack_req(OP_REPORT, '0, '0, 8'h10, 1'b0));
        request_queue.push_back(pack_req(OP_REPORT, '0, 32'h77, 8'h20, 1'b0));
        request_queue.push_back(pack_req(OP_FINISH, '0, '0, '0, 1'b1));
        request_queue.push_back(pack_req(OP_FINISH, '0, '0, '0, 1'b0));
        request_queue.push_back(pack_req(OP_CLEAR, '1, '1, '1, 1'b1));
        for (int i = 0; i < 18; i++)
            request_queue.push_back(pack_req(OP_REPORT, 48'(i + 100), 32'(i), 8'(i % 3), 1'b0));
        request_queue.push_back(pack_req(OP_FINISH, '0, '0, '0, 1'b1));

        // random scans: usually a clear, then reports, one or two finishes, some noise
        for (int sc = 0; sc < 30; sc++) begin
            n_scan = $urandom_range(0, 25);
            pool = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
                request_queue.push_back(pack_req(OP_CLEAR, 48'({$urandom, $urandom}),
                                        $urandom, 8'($urandom), 1'($urandom)));
            for (int i = 0; i < n_scan; i++) begin
                if ($urandom_range(0, 29) == 0)
                    request_queue.push_back(pack_req(OP_IGNORED, 48'({$urandom, $urandom}),
                                            $urandom, 8'($urandom), 1'($urandom)));
                request_queue.push_back(pack_req(OP_REPORT, pool_addr(pool),
                    ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom),
                    ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7) - 4) : 8'($urandom),
                    1'($urandom)));
            end
            request_queue.push_back(pack_req(OP_FINISH, 48'({$urandom, $urandom}),
                                    $urandom, 8'($urandom), 1'($urandom)));
            if ($urandom_range(0, 4) == 0)
                request_queue.push_back(pack_req(OP_FINISH, 48'({$urandom, $urandom}),
                                        $urandom, 8'($urandom), 1'($urandom)));
        end

        wait (request_queue.size() == 0 && !s_tvalid);
        wait (readout_queue.size() == 0);
        repeat (400) @(posedge clk);
        if (mismatch_count == 0 && readout_queue.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule

@@ sim.f @@
sv/sst_pkg.sv
sv/sst_ram.sv
sv/strongest_signal_table.sv
sim/testbench.sv
